// ===== rtl/bod_pkg.sv =====
// Package with the constants and codes of the banded OKVS decoder.
`timescale 1ns / 1ps
`default_nettype none

package bod_pkg;

  localparam int KEY_BYTES    = 16;
  localparam int KEY_W        = 128;
  localparam int RANGE_W      = 10;
  localparam int BAND_W       = 8;
  localparam int INDEX_W      = 10;
  localparam int WORD_W       = 32;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 10;
  localparam int IN_DATA_W    = 208;
  localparam int MOD_BITS     = 4;
  localparam int MOD_CNT_W    = 5;
  localparam int ALIGN_BITS   = 3;
  localparam int ADDR_SUM_W   = 11;

  localparam logic [RANGE_W-1:0] RANGE_RESET = 10'd896;
  localparam logic [BAND_W-1:0]  BAND_RESET  = 8'd128;
  localparam logic [BAND_W-1:0]  BAND_MAX    = 8'd128;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_BITS  = 1'd1;

  localparam int KEY_LOW_LSB   = 0;
  localparam int KEY_HIGH_LSB  = 64;
  localparam int INDEX_LSB     = 128;
  localparam int ENTRY_LSB     = 138;
  localparam int INITIAL_LSB   = 170;

endpackage

`default_nettype wire

// ===== rtl/banded_okvs_decode.sv =====
// Top level of the banded OKVS decoder: table memory, modulo unit and band walk.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata, s_tuser = cmd
//   m_*     | out | m_tvalid/m_tready  | m_tdata = decoded_value
//   cfg_*   | in  | cfg_wen            | cfg_addr, cfg_wdata
//
// Load transaction: the table is written in the accept cycle.
// Decode transaction: modulo at 4 key bits per cycle through one compare-subtract
// chain, then L = min(band_bits,128) table reads at one per cycle on the single
// read port, then the drain state and the output hand-off state, which waits for
// the output register to free; s_tready returns when the hand-off is done.
// After reset a clearing pass writes TABLE_DEPTH zeros; s_tready stays low until it ends.
// A waiting result in m_tdata does not block the next transaction; a second
// result holds in the sequencer until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module banded_okvs_decode
  import bod_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // key_low[63:0], key_high[127:64], table_index[137:128],
  // entry_value[169:138], initial_value[201:170], zero pad [207:202]
  input  wire  [IN_DATA_W-1:0]  s_tdata,
  // cmd[0]
  input  wire                   s_tuser,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // decoded_value[31:0]
  output logic [WORD_W-1:0]     m_tdata,
  input  wire                   cfg_wen,
  input  wire  [CFG_ADDR_W-1:0] cfg_addr,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]              state;
  logic [AW-1:0]           clr_addr;
  logic [RANGE_W-1:0]      range_size;
  logic [BAND_W-1:0]       band_bits;
  logic [KEY_W-1:0]        mod_key;
  logic [KEY_W-1:0]        band_vec;
  logic [RANGE_W-1:0]      rem;
  logic [RANGE_W-1:0]      rem_next;
  logic [MOD_CNT_W-1:0]    mod_cnt;
  logic [RANGE_W-1:0]      start;
  logic [BAND_W-1:0]       walk_idx;
  logic [BAND_W-1:0]       walk_len;
  logic                    hit;
  logic [WORD_W-1:0]       acc;
  logic [WORD_W-1:0]       rd_data;
  logic [WORD_W-1:0]       band_table [TABLE_DEPTH];

  logic                    accept;
  logic                    load_we;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [WORD_W-1:0]       mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [KEY_W-1:0]        key_masked;
  logic [KEY_W-1:0]        band_init;
  logic [ADDR_SUM_W-1:0]   addr_sum;
  logic                    addr_ok;
  logic [INDEX_W-1:0]      in_index;
  logic                    out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_index = s_tdata[INDEX_LSB +: INDEX_W];
  assign load_we  = accept && (s_tuser == CMD_LOAD) && (32'(in_index) < TABLE_DEPTH);
  assign out_free = !m_tvalid || m_tready;
  assign walk_len = (band_bits > BAND_MAX) ? BAND_MAX : band_bits;

  // mask bytes past the key and reorder so band bit j sits at bit j
  always_comb begin
    key_masked = s_tdata[KEY_LOW_LSB +: KEY_W];
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (b >= KEY_BYTES) begin
        key_masked[8*b +: 8] = 8'h00;
      end
    end
    for (int i = 0; i < KEY_W; i++) begin
      band_init[i] = key_masked[i ^ 7];
    end
  end

  // single compare-subtract chain: four key bits per cycle
  always_comb begin
    logic [RANGE_W:0] trial;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < MOD_BITS; k++) begin
      trial = {rem_next, mod_key[KEY_W-1-k]};
      if (trial >= {1'b0, range_size}) begin
        trial = trial - {1'b0, range_size};
      end
      rem_next = trial[RANGE_W-1:0];
    end
    if (range_size == '0) begin
      rem_next = '0;
    end
  end

  assign addr_sum  = {1'b0, start} + {4'b0, walk_idx[6:0]};
  assign addr_ok   = 32'(addr_sum) < TABLE_DEPTH;
  assign mem_raddr = AW'(addr_sum);

  always_comb begin
    mem_we    = load_we;
    mem_waddr = AW'(in_index);
    mem_wdata = s_tdata[ENTRY_LSB +: WORD_W];
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      band_table[mem_waddr] <= mem_wdata;
    end
    rd_data <= band_table[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_size <= RANGE_RESET;
      band_bits  <= BAND_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_RANGE_SIZE: range_size <= cfg_wdata;
        REG_BAND_BITS:  band_bits  <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      hit      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      hit <= (state == ST_WALK) && band_vec[0] && addr_ok;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (s_tuser == CMD_DECODE)) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_cnt == '1) begin
            state <= (walk_len == '0) ? ST_DRAIN : ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_idx == walk_len - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mod_key  <= key_masked;
      band_vec <= band_init;
      rem      <= '0;
      mod_cnt  <= '0;
      walk_idx <= '0;
      acc      <= s_tdata[INITIAL_LSB +: WORD_W];
    end else begin
      if (state == ST_MOD) begin
        mod_key <= {mod_key[KEY_W-1-MOD_BITS:0], {MOD_BITS{1'b0}}};
        rem     <= rem_next;
        mod_cnt <= mod_cnt + 1'b1;
        if (mod_cnt == '1) begin
          start <= {rem_next[RANGE_W-1:ALIGN_BITS], {ALIGN_BITS{1'b0}}};
        end
      end
      if (state == ST_WALK) begin
        band_vec <= {1'b0, band_vec[KEY_W-1:1]};
        walk_idx <= walk_idx + 1'b1;
      end
      if (hit) begin
        acc <= acc ^ rd_data;
      end
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= acc;
    end
  end

`ifndef NO_ASSERTIONS
  a_hit_from_walk: assert property (@(posedge clk) disable iff (rst)
    hit |-> $past(state) == ST_WALK)
    else $error("band hit without a table read");

  a_walk_in_band: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> walk_idx < walk_len)
    else $error("band walk past its length");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    load_we |-> state == ST_IDLE)
    else $error("table load outside idle");

  a_done_to_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> m_tvalid && state == ST_IDLE)
    else $error("result not handed to output register");
`endif

endmodule

`default_nettype wire

// ===== dv/bod_checker.sv =====
// Checker for the banded OKVS decoder: tracks table and registers, predicts and compares results.
`timescale 1ns / 1ps

module bod_checker
  import bod_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [WORD_W-1:0]     m_tdata,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  logic [WORD_W-1:0]  band_words [TABLE_DEPTH];
  logic [RANGE_W-1:0] range_size_q;
  logic [BAND_W-1:0]  band_bits_q;
  logic [WORD_W-1:0]  decoded_fifo [$];
  int                 fail_count = 0;

  function automatic logic [WORD_W-1:0] band_xor(input logic [KEY_W-1:0] key,
                                                 input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] acc;
    logic [KEY_W-1:0]  rem;
    int                start;
    int                addr;
    int                walk;
    acc   = seed;
    start = 0;
    if (range_size_q != '0) begin
      rem   = key % KEY_W'(range_size_q);
      start = (int'(rem[RANGE_W-1:0]) / 8) * 8;
    end
    walk = (int'(band_bits_q) > KEY_W) ? KEY_W : int'(band_bits_q);
    for (int j = 0; j < walk; j++) begin
      addr = start + j;
      if (key[8 * (j / 8) + 7 - (j % 8)] && addr < TABLE_DEPTH)
        acc ^= band_words[addr];
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    logic [WORD_W-1:0]  want;
    logic [INDEX_W-1:0] idx;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        band_words[i] = '0;
      range_size_q = RANGE_RESET;
      band_bits_q  = BAND_RESET;
      decoded_fifo.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_addr == REG_RANGE_SIZE)
          range_size_q = cfg_wdata[RANGE_W-1:0];
        else if (cfg_addr == REG_BAND_BITS)
          band_bits_q = cfg_wdata[BAND_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD) begin
          idx = s_tdata[INDEX_LSB +: INDEX_W];
          if (int'(idx) < TABLE_DEPTH)
            band_words[idx] = s_tdata[ENTRY_LSB +: WORD_W];
        end else begin
          decoded_fifo.push_back(band_xor(s_tdata[KEY_W-1:0],
                                          s_tdata[INITIAL_LSB +: WORD_W]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (decoded_fifo.size() == 0) begin
          $error("decoded_value: expected none, actual %h", m_tdata);
          fail_count++;
        end else begin
          want = decoded_fifo.pop_front();
          if (m_tdata !== want) begin
            $error("decoded_value: expected %h, actual %h", want, m_tdata);
            fail_count++;
          end
        end
      end
    end
    errors  <= fail_count;
    pending <= decoded_fifo.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top-level testbench of the banded OKVS decoder: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import bod_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 140;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [WORD_W-1:0]     m_tdata;
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors;
  int                    pending;
  bit                    calm = 1'b0;
  int unsigned           ready_hold = 0;
  int                    cycles = 0;

  banded_okvs_decode dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  bod_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold off the result side for a random number of cycles after each transaction
  always @(posedge clk) begin
    if (m_tvalid && m_tready)
      ready_hold = calm ? 0 : $urandom_range(0, 4);
    else if (ready_hold != 0)
      ready_hold--;
    m_tready <= (ready_hold == 0);
  end

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return KEY_W'($urandom_range(0, 2047));
      3: return KEY_W'($urandom_range(0, 255)) << (8 * $urandom_range(0, 15));
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] rand_index();
    case ($urandom_range(0, 3))
      0: return INDEX_W'($urandom_range(0, 160));
      1: return INDEX_W'($urandom_range(880, 1023));
      default: return INDEX_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack(input logic [KEY_W-1:0] key,
                                                input logic [INDEX_W-1:0] idx,
                                                input logic [WORD_W-1:0] entry,
                                                input logic [WORD_W-1:0] init);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[KEY_W-1:0]              = key;
    d[INDEX_LSB +: INDEX_W]   = idx;
    d[ENTRY_LSB +: WORD_W]    = entry;
    d[INITIAL_LSB +: WORD_W]  = init;
    return d;
  endfunction

  task automatic send(input logic cmd, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic load(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] entry);
    send(CMD_LOAD, pack(rand_key(), idx, entry, rand_word()));
  endtask

  task automatic decode(input logic [KEY_W-1:0] key, input logic [WORD_W-1:0] init);
    send(CMD_DECODE, pack(key, rand_index(), rand_word(), init));
  endtask

  // drop valid and wait until every decoded word has come back
  task automatic drain(input int tail);
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] range_val,
                            input logic [CFG_DATA_W-1:0] band_val);
    drain(16);
    cfg_wen   <= 1'b1;
    cfg_addr  <= REG_RANGE_SIZE;
    cfg_wdata <= range_val;
    @(posedge clk);
    cfg_addr  <= REG_BAND_BITS;
    cfg_wdata <= band_val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] range_val;
    logic [CFG_DATA_W-1:0] band_val;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_LOAD;
    m_tready  = 1'b0;
    cfg_wen   = 1'b0;
    cfg_addr  = REG_RANGE_SIZE;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    decode('0, '0);
    decode('1, '1);
    load(INDEX_W'(0), '1);
    load(INDEX_W'(1023), 32'h8000_0001);
    load(INDEX_W'(1015), '0);
    for (int i = 1; i < 8; i++)
      load(INDEX_W'(i), $urandom);
    for (int i = 888; i < 896; i++)
      load(INDEX_W'(i), $urandom);
    decode(KEY_W'(7), '0);
    decode(KEY_W'(895), $urandom);
    decode({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, '1);
    decode({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, $urandom);
    decode({$urandom, $urandom, $urandom, $urandom}, $urandom);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin range_val = 10'd1;    band_val = 10'd1;   end
        1: begin range_val = 10'd1023; band_val = 10'd255; end
        2: begin range_val = 10'd0;    band_val = 10'd0;   end
        3: begin range_val = 10'd896;  band_val = 10'd128; end
        4: begin range_val = 10'd8;    band_val = 10'd64;  end
        5: begin range_val = 10'd200;  band_val = 10'd17;  end
        default: begin
          range_val = CFG_DATA_W'($urandom_range(0, 1023));
          band_val  = CFG_DATA_W'($urandom_range(0, 1023));
        end
      endcase
      set_config(range_val, band_val);
      decode(KEY_W'(range_val) - 1, $urandom);
      decode('1, $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0)
          calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 45)
          load(rand_index(), rand_word());
        else
          decode(rand_key(), rand_word());
      end
      calm = 1'b0;
    end

    drain(200);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
